FILE: sv/pge_pkg.sv
// ----------------------------------------------------------------------------
// pge_pkg
// shared constants, codes and controller/datapath interface types for the
// polynomial grid evaluator
// ----------------------------------------------------------------------------
package pge_pkg;

  // number formats
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 16;
  localparam int TERM_W    = 3;
  localparam int MAX_TERMS = 4;
  localparam int SEL_W     = $clog2(MAX_TERMS);
  localparam int CFG_IDX_W = 3;

  // grid divider: 48-bit dividend magnitude, two quotient bits per step
  localparam int NUM_W      = DATA_W + CNT_W;
  localparam int DIV_STEPS  = NUM_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_START  = 3'd0,
    REG_GRID_END    = 3'd1,
    REG_POINT_COUNT = 3'd2,
    REG_TERM_COUNT  = 3'd3,
    REG_COEF_0      = 3'd4,
    REG_COEF_1      = 3'd5,
    REG_COEF_2      = 3'd6,
    REG_COEF_3      = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_CFG = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_XADD,
    S_HMUL,
    S_HADD,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic             load_in;
    logic             mul;
    logic             div_step;
    logic             x_add;
    logic             y_init;
    logic             h_mul;
    logic             h_add;
    logic             load_out;
    logic [SEL_W-1:0] h_sel;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    status_t           status;
    logic [TERM_W-1:0] terms;
    logic              out_full;
  } stat_t;

endpackage

FILE: sv/pge_dpath.sv
// ----------------------------------------------------------------------------
// pge_dpath
// config registers, grid multiply and radix-4 divider, horner multiply/add
// with saturation, and the output word register
// ----------------------------------------------------------------------------
module pge_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pge_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pge_pkg::DATA_W-1:0]          cfg_data,
  input  logic [pge_pkg::CNT_W-1:0]           point_index,
  input  pge_pkg::cmd_t                       cmd,
  output pge_pkg::stat_t                      stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [pge_pkg::DATA_W-1:0]   x_value,
  output logic signed [pge_pkg::DATA_W-1:0]   y_value,
  output logic [1:0]                          status,
  output logic                                saturated
);

  localparam int W  = pge_pkg::DATA_W;
  localparam int NW = pge_pkg::NUM_W;
  localparam int CW = pge_pkg::CNT_W;
  localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

  // configuration
  logic signed [W-1:0]                grid_start;
  logic signed [W-1:0]                grid_end;
  logic [CW-1:0]                      point_count;
  logic [pge_pkg::TERM_W-1:0]         term_count;
  logic signed [W-1:0]                coef [pge_pkg::MAX_TERMS];

  // working registers
  logic [CW-1:0]                      idx;
  pge_pkg::status_t                   st;
  logic                               neg;
  logic [NW-1:0]                      dvd;
  logic [CW-1:0]                      rem;
  logic signed [W-1:0]                x_reg;
  logic signed [W-1:0]                y_reg;
  logic signed [2*W-1:0]              prod;
  logic                               sat_flag;

  logic [pge_pkg::TERM_W-1:0]         terms_eff;
  logic                               cfg_bad;
  logic signed [W:0]                  diff;
  logic signed [NW+1:0]               num;
  logic signed [NW+1:0]               mag;
  logic [CW-1:0]                      den;
  logic [CW:0]                        r1, r1s, r2, r2s;
  logic                               ge1, ge2;
  logic signed [W+1:0]                qs;
  logic signed [W+1:0]                xs;
  logic signed [2*W-1:0]              sh;
  logic signed [W-1:0]                p32;
  logic                               p_sat;
  logic signed [W:0]                  sum;
  logic signed [W-1:0]                coef_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_start  <= '0;
      grid_end    <= W'(65536);
      point_count <= CW'(2);
      term_count  <= pge_pkg::TERM_W'(2);
      coef[0]     <= '0;
      coef[1]     <= W'(65536);
      coef[2]     <= '0;
      coef[3]     <= '0;
    end else if (cfg_we) begin
      case (pge_pkg::reg_idx_t'(cfg_index))
        pge_pkg::REG_GRID_START:  grid_start  <= cfg_data;
        pge_pkg::REG_GRID_END:    grid_end    <= cfg_data;
        pge_pkg::REG_POINT_COUNT: point_count <= cfg_data[CW-1:0];
        pge_pkg::REG_TERM_COUNT:  term_count  <= cfg_data[pge_pkg::TERM_W-1:0];
        pge_pkg::REG_COEF_0:      coef[0]     <= cfg_data;
        pge_pkg::REG_COEF_1:      coef[1]     <= cfg_data;
        pge_pkg::REG_COEF_2:      coef[2]     <= cfg_data;
        pge_pkg::REG_COEF_3:      coef[3]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp term count and check the configuration
  assign terms_eff = (term_count > pge_pkg::TERM_W'(pge_pkg::MAX_TERMS))
                     ? pge_pkg::TERM_W'(pge_pkg::MAX_TERMS) : term_count;
  assign cfg_bad   = (point_count < CW'(2)) || (grid_start == grid_end) ||
                     (terms_eff < pge_pkg::TERM_W'(2));

  // grid numerator, magnitude for the unsigned divider
  assign diff = {grid_end[W-1], grid_end} - {grid_start[W-1], grid_start};
  assign num  = diff * $signed({1'b0, idx});
  assign mag  = num[NW+1] ? -num : num;
  assign den  = point_count - CW'(1);

  // two restoring steps per cycle
  always_comb begin
    r1  = {rem, dvd[NW-1]};
    ge1 = (r1 >= {1'b0, den});
    r1s = ge1 ? (r1 - {1'b0, den}) : r1;
    r2  = {r1s[CW-1:0], dvd[NW-2]};
    ge2 = (r2 >= {1'b0, den});
    r2s = ge2 ? (r2 - {1'b0, den}) : r2;
  end

  // quotient is below 2^32, apply sign and offset
  always_comb begin
    qs = {2'b00, dvd[W-1:0]};
    if (neg) begin
      qs = -qs;
    end
    xs = {{2{grid_start[W-1]}}, grid_start} + qs;
  end

  // horner step: floor shift, saturate, add coefficient, saturate
  assign coef_sel = coef[cmd.h_sel];
  always_comb begin
    sh    = prod >>> pge_pkg::FRAC_BITS;
    p_sat = (sh[2*W-1:W-1] != {(W+1){1'b0}}) && (sh[2*W-1:W-1] != {(W+1){1'b1}});
    p32   = p_sat ? (sh[2*W-1] ? S_MIN : S_MAX) : sh[W-1:0];
    sum   = {p32[W-1], p32} + {coef_sel[W-1], coef_sel};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      idx      <= point_index;
      sat_flag <= 1'b0;
      if (cfg_bad) begin
        st <= pge_pkg::STATUS_BAD_CFG;
      end else if (point_index >= point_count) begin
        st <= pge_pkg::STATUS_RANGE;
      end else begin
        st <= pge_pkg::STATUS_OK;
      end
    end
    if (cmd.mul) begin
      neg <= num[NW+1];
      dvd <= mag[NW-1:0];
      rem <= '0;
    end
    if (cmd.div_step) begin
      dvd <= {dvd[NW-3:0], ge1, ge2};
      rem <= r2s[CW-1:0];
    end
    if (cmd.x_add) begin
      x_reg <= xs[W-1:0];
    end
    if (cmd.y_init) begin
      y_reg <= coef_sel;
    end
    if (cmd.h_mul) begin
      prod <= y_reg * x_reg;
    end
    if (cmd.h_add) begin
      if (sum[W] != sum[W-1]) begin
        y_reg <= sum[W] ? S_MIN : S_MAX;
      end else begin
        y_reg <= sum[W-1:0];
      end
      if (p_sat || (sum[W] != sum[W-1])) begin
        sat_flag <= 1'b1;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= st;
      if (st == pge_pkg::STATUS_OK) begin
        x_value   <= x_reg;
        y_value   <= y_reg;
        saturated <= sat_flag;
      end else begin
        x_value   <= '0;
        y_value   <= '0;
        saturated <= 1'b0;
      end
    end
  end

  assign stat.status   = st;
  assign stat.terms    = terms_eff;
  assign stat.out_full = out_valid;

endmodule

FILE: sv/pge_ctrl.sv
// ----------------------------------------------------------------------------
// pge_ctrl
// sequencer: check, grid divide, horner loop, hand off to output register
// ----------------------------------------------------------------------------
module pge_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  input  pge_pkg::stat_t stat,
  output pge_pkg::cmd_t  cmd
);

  pge_pkg::state_t                   state, state_next;
  logic [pge_pkg::DIV_CNT_W-1:0]     div_cnt, div_cnt_next;
  logic [pge_pkg::SEL_W-1:0]         hsel, hsel_next;
  logic [pge_pkg::TERM_W-1:0]        top_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pge_pkg::S_IDLE;
      div_cnt <= '0;
      hsel    <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
      hsel    <= hsel_next;
    end
  end

  assign top_term = stat.terms - pge_pkg::TERM_W'(1);

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    hsel_next    = hsel;
    cmd          = '0;
    cmd.h_sel    = hsel;
    in_ready     = 1'b0;
    case (state)
      pge_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = pge_pkg::S_CHECK;
        end
      end
      pge_pkg::S_CHECK: begin
        if (stat.status != pge_pkg::STATUS_OK) begin
          state_next = pge_pkg::S_OUT;
        end else begin
          cmd.mul      = 1'b1;
          div_cnt_next = '0;
          state_next   = pge_pkg::S_DIV;
        end
      end
      pge_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + pge_pkg::DIV_CNT_W'(1);
        if (div_cnt == pge_pkg::DIV_CNT_W'(pge_pkg::DIV_STEPS - 1)) begin
          state_next = pge_pkg::S_XADD;
        end
      end
      pge_pkg::S_XADD: begin
        // y starts at the highest coefficient in use
        cmd.x_add  = 1'b1;
        cmd.y_init = 1'b1;
        cmd.h_sel  = top_term[pge_pkg::SEL_W-1:0];
        hsel_next  = top_term[pge_pkg::SEL_W-1:0] - pge_pkg::SEL_W'(1);
        state_next = pge_pkg::S_HMUL;
      end
      pge_pkg::S_HMUL: begin
        cmd.h_mul  = 1'b1;
        state_next = pge_pkg::S_HADD;
      end
      pge_pkg::S_HADD: begin
        cmd.h_add = 1'b1;
        if (hsel == '0) begin
          state_next = pge_pkg::S_OUT;
        end else begin
          hsel_next  = hsel - pge_pkg::SEL_W'(1);
          state_next = pge_pkg::S_HMUL;
        end
      end
      pge_pkg::S_OUT: begin
        if (!stat.out_full || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = pge_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pge_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/polynomial_grid_evaluator.sv
// sequence: each word runs through the radix-4 grid divider (24 steps) and the shared
//   horner multiplier, one multiply and one add per horner step; an error result skips
//   both. throughput: a new word is taken only once the last result is handed to the
//   output register, which waits while that register is held full; the next word is
//   taken while the result waits there
// reset: synchronous active-high rst restores the register defaults and empties the block
// ----------------------------------------------------------------------------
// polynomial_grid_evaluator
// returns x and p(x) for one point of an evenly spaced Q16.16 grid
// ----------------------------------------------------------------------------
module polynomial_grid_evaluator (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [pge_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pge_pkg::DATA_W-1:0]          cfg_data,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pge_pkg::CNT_W-1:0]           point_index,
  // output words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pge_pkg::DATA_W-1:0]   x_value,
  output logic signed [pge_pkg::DATA_W-1:0]   y_value,
  output logic [1:0]                          status,
  output logic                                saturated
);

  // command and status between sequencer and datapath
  pge_pkg::cmd_t  cmd;
  pge_pkg::stat_t stat;

  // sequencer: accepts a word only when idle, walks divide then horner steps unless the
  // check fails, waits for room in the output register before handing the result over
  pge_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: config registers, grid multiply, divider, horner multiply-add
  // with saturation tracking, and the output register
  pge_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point_index (point_index),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .x_value     (x_value),
    .y_value     (y_value),
    .status      (status),
    .saturated   (saturated)
  );

endmodule

FILE: tb/grid_point_checker.sv
// ----------------------------------------------------------------------------
// grid_point_checker
// watches the config port and both word channels of the polynomial grid
// evaluator, predicts each grid point in 64-bit arithmetic and compares the
// result words field by field in order
// ----------------------------------------------------------------------------
module grid_point_checker
  import pge_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [DATA_W-1:0]           cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [CNT_W-1:0]            point_index,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [DATA_W-1:0]    x_value,
  input  logic signed [DATA_W-1:0]    y_value,
  input  logic [1:0]                  status,
  input  logic                        saturated,
  output int                          mismatches,
  output int                          points_due
);

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -(64'sd1 <<< 31);

  typedef struct {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    status_t                  st;
    logic                     sat;
  } grid_point_t;

  // shadow copy of the register file
  logic signed [DATA_W-1:0] grid_lo;
  logic signed [DATA_W-1:0] grid_hi;
  logic [CNT_W-1:0]         point_total;
  logic [TERM_W-1:0]        term_total;
  logic signed [DATA_W-1:0] coef [MAX_TERMS];

  grid_point_t expected_points [$];

  function automatic longint clip32(input longint v, inout logic hit);
    if (v > S32_HI) begin
      hit = 1'b1;
      return S32_HI;
    end
    if (v < S32_LO) begin
      hit = 1'b1;
      return S32_LO;
    end
    return v;
  endfunction

  function automatic grid_point_t predict_point(input logic [CNT_W-1:0] idx);
    grid_point_t r;
    longint      span;
    longint      acc;
    longint      prod;
    logic        clipped;
    int          terms;
    int          j;
    r.x     = '0;
    r.y     = '0;
    r.st    = STATUS_OK;
    r.sat   = 1'b0;
    clipped = 1'b0;
    terms   = (term_total > MAX_TERMS) ? MAX_TERMS : int'(term_total);
    if (point_total < 2 || grid_lo == grid_hi || terms < 2) begin
      r.st = STATUS_BAD_CFG;
    end else if (idx >= point_total) begin
      r.st = STATUS_RANGE;
    end else begin
      // quotient truncates toward zero, as longint division does
      span = longint'(grid_hi) - longint'(grid_lo);
      acc  = longint'(grid_lo) + (span * longint'(idx)) / (longint'(point_total) - 1);
      r.x  = acc[DATA_W-1:0];
      // horner: arithmetic shift gives the floor of the product
      acc = longint'(coef[terms-1]);
      for (j = terms - 2; j >= 0; j--) begin
        prod = clip32((acc * longint'(r.x)) >>> FRAC_BITS, clipped);
        acc  = clip32(prod + longint'(coef[j]), clipped);
      end
      r.y   = acc[DATA_W-1:0];
      r.sat = clipped;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    grid_point_t want;
    if (rst) begin
      grid_lo     <= '0;
      grid_hi     <= 32'sh0001_0000;
      point_total <= 16'd2;
      term_total  <= 3'd2;
      coef[0]     <= '0;
      coef[1]     <= 32'sh0001_0000;
      coef[2]     <= '0;
      coef[3]     <= '0;
      expected_points.delete();
      mismatches = 0;
      points_due <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result word: x_value %0d y_value %0d", x_value, y_value);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (x_value !== want.x) begin
            $error("x_value: expected %0d, got %0d", want.x, x_value);
            mismatches++;
          end
          if (y_value !== want.y) begin
            $error("y_value: expected %0d, got %0d", want.y, y_value);
            mismatches++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            mismatches++;
          end
          if (saturated !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, saturated);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_points.push_back(predict_point(point_index));
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_GRID_START:  grid_lo     <= cfg_data;
          REG_GRID_END:    grid_hi     <= cfg_data;
          REG_POINT_COUNT: point_total <= cfg_data[CNT_W-1:0];
          REG_TERM_COUNT:  term_total  <= cfg_data[TERM_W-1:0];
          REG_COEF_0:      coef[0]     <= cfg_data;
          REG_COEF_1:      coef[1]     <= cfg_data;
          REG_COEF_2:      coef[2]     <= cfg_data;
          REG_COEF_3:      coef[3]     <= cfg_data;
          default: ;
        endcase
      end
      points_due <= expected_points.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// regression for the polynomial grid evaluator: directed corner points, then
// random grids and polynomials with random idling on both word channels;
// checking is done by grid_point_checker beside the block
// ----------------------------------------------------------------------------
module testbench;
  import pge_pkg::*;

  localparam int RANDOM_PHASES   = 30;
  localparam int POINTS_PER_RUN  = 50;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES     = 64;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;

  // one full register file setting
  typedef struct packed {
    logic [DATA_W-1:0]           lo;
    logic [DATA_W-1:0]           hi;
    logic [CNT_W-1:0]            count;
    logic [TERM_W-1:0]           terms;
    logic [3:0][DATA_W-1:0]      coef;
  } grid_setup_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CNT_W-1:0]         point_index = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] x_value;
  logic signed [DATA_W-1:0] y_value;
  logic [1:0]               status;
  logic                     saturated;
  int                       mismatches;
  int                       points_due;
  logic                     steady = 1'b0;   // no idling on either side while set
  int                       quiet_cycles = 0;

  always #2 clk = ~clk;

  polynomial_grid_evaluator i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .point_index (point_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .x_value     (x_value),
    .y_value     (y_value),
    .status      (status),
    .saturated   (saturated)
  );

  grid_point_checker i_grid_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .point_index (point_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .x_value     (x_value),
    .y_value     (y_value),
    .status      (status),
    .saturated   (saturated),
    .mismatches  (mismatches),
    .points_due  (points_due)
  );

  // receiver holds out_ready low about 7 percent of the time
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 7);
  end

  // watchdog: any accepted word or register write counts as progress
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("polynomial_grid_evaluator regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one register write per cycle; the caller lowers cfg_we after the last
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic apply_setup(input grid_setup_t s);
    write_reg(REG_GRID_START, s.lo);
    write_reg(REG_GRID_END, s.hi);
    write_reg(REG_POINT_COUNT, DATA_W'(s.count));
    write_reg(REG_TERM_COUNT, DATA_W'(s.terms));
    write_reg(REG_COEF_0, s.coef[0]);
    write_reg(REG_COEF_1, s.coef[1]);
    write_reg(REG_COEF_2, s.coef[2]);
    write_reg(REG_COEF_3, s.coef[3]);
    cfg_we <= 1'b0;
  endtask

  // valid stays high after acceptance until the next word or an explicit gap,
  // so valid is never lowered and raised in the same step
  task automatic send_point(input logic [CNT_W-1:0] idx);
    in_valid    <= 1'b1;
    point_index <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender idles in about 7 of 100 words, gap length spread over the latency
  task automatic sender_gap();
    if (!steady && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  // hold off the sender until every predicted word has come back; the extra
  // edge lets the checker count a word accepted on the edge we resumed from
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (points_due != 0) @(posedge clk);
  endtask

  function automatic grid_setup_t make_setup(
    input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
    input logic [CNT_W-1:0] count, input logic [TERM_W-1:0] terms,
    input logic [DATA_W-1:0] c0, input logic [DATA_W-1:0] c1,
    input logic [DATA_W-1:0] c2, input logic [DATA_W-1:0] c3);
    grid_setup_t s;
    s.lo      = lo;
    s.hi      = hi;
    s.count   = count;
    s.terms   = terms;
    s.coef[0] = c0;
    s.coef[1] = c1;
    s.coef[2] = c2;
    s.coef[3] = c3;
    return s;
  endfunction

  task automatic directed_phase(input grid_setup_t s, input logic [CNT_W-1:0] picks[$]);
    drain_results();
    apply_setup(s);
    foreach (picks[k]) send_point(picks[k]);
  endtask

  // small values in +-span/2, as a Q16.16 word
  function automatic logic [DATA_W-1:0] near_zero(input int unsigned span);
    return DATA_W'(int'($urandom_range(span)) - int'(span / 2));
  endfunction

  // mostly well-formed grids with modest ranges; some full-range and some
  // invalid settings mixed in
  function automatic grid_setup_t random_setup();
    grid_setup_t s;
    int          pick;
    int          k;
    pick = $urandom_range(99);
    if (pick < 15) begin
      s.lo = $urandom;
      s.hi = $urandom;
    end else begin
      s.lo = near_zero(1048576);
      s.hi = near_zero(1048576);
    end
    // equal limits make the setting invalid
    if ($urandom_range(99) < 4) s.hi = s.lo;
    pick = $urandom_range(99);
    if (pick < 5)       s.count = CNT_W'($urandom_range(1));
    else if (pick < 15) s.count = CNT_W'($urandom_range(65534, 65535));
    else                s.count = CNT_W'($urandom_range(2, 300));
    pick = $urandom_range(99);
    if (pick < 8)       s.terms = TERM_W'($urandom_range(1));
    else if (pick < 16) s.terms = TERM_W'($urandom_range(5, 7));
    else                s.terms = TERM_W'($urandom_range(2, 4));
    for (k = 0; k < 4; k++) begin
      if ($urandom_range(99) < 70) s.coef[k] = near_zero(262144);
      else                         s.coef[k] = $urandom;
    end
    return s;
  endfunction

  // mostly points on the grid, some at the last point or just past it, some
  // anywhere in the 16-bit range
  function automatic logic [CNT_W-1:0] pick_index(input logic [CNT_W-1:0] count);
    int pick;
    pick = $urandom_range(99);
    if (count == 0 || pick >= 92) return CNT_W'($urandom_range(65535));
    if (pick < 85) return CNT_W'($urandom_range(count - 1));
    return $urandom_range(1) ? count : count - 16'd1;
  endfunction

  initial begin
    grid_setup_t s;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // register defaults: x from 0 to 1.0 in two points, y = x;
    // indexes past the end report out of range
    send_point(16'd0);
    send_point(16'd1);
    send_point(16'd2);
    send_point(16'hffff);

    // full-range grid with extreme cubic coefficients: products clip both ways,
    // index bits walk through both values
    directed_phase(make_setup(Q_MIN, Q_MAX, 16'd65535, 3'd4, Q_MAX, Q_MIN, Q_MAX, Q_MIN),
                   '{16'd0, 16'd65534, 16'd32767, 16'h5555, 16'haaaa, 16'd65535});

    // invalid setting wins over an out-of-range index
    directed_phase(make_setup(0, Q_ONE, 16'd1, 3'd2, 0, Q_ONE, 0, 0),
                   '{16'd0, 16'hffff});
    // equal grid limits
    directed_phase(make_setup(Q_ONE, Q_ONE, 16'd10, 3'd3, Q_ONE, Q_ONE, Q_ONE, 0),
                   '{16'd3});
    // fewer than two terms
    directed_phase(make_setup(0, Q_ONE, 16'd10, 3'd0, Q_ONE, Q_ONE, 0, 0), '{16'd1});
    directed_phase(make_setup(0, Q_ONE, 16'd10, 3'd1, Q_ONE, Q_ONE, 0, 0), '{16'd1});
    // no points at all
    directed_phase(make_setup(0, Q_ONE, 16'd0, 3'd2, 0, Q_ONE, 0, 0), '{16'd0});

    // descending grid whose step does not divide evenly (negative quotient
    // truncates toward zero), term count above the maximum clamps to four,
    // negative products exercise the floor shift; last point lands on the end
    directed_phase(make_setup(32'h0002_0000, 32'hfffe_0001, 16'd7, 3'd7,
                              32'h0000_8000, 32'hffff_4000, 32'h0000_c000, 32'hffff_e000),
                   '{16'd0, 16'd1, 16'd3, 16'd5, 16'd6});

    // random grids and polynomials; one run has no idling at all
    for (int run = 0; run < RANDOM_PHASES; run++) begin
      s = random_setup();
      drain_results();
      steady <= (run == 4);
      apply_setup(s);
      repeat (POINTS_PER_RUN) begin
        sender_gap();
        send_point(pick_index(s.count));
      end
    end

    drain_results();
    // catch any stray word after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && points_due == 0) begin
      $display("polynomial_grid_evaluator regression: pass");
    end else begin
      $display("polynomial_grid_evaluator regression: fail");
    end
    $finish;
  end

endmodule

FILE: polynomial_grid_evaluator.f
sv/pge_pkg.sv
sv/pge_dpath.sv
sv/pge_ctrl.sv
sv/polynomial_grid_evaluator.sv
tb/grid_point_checker.sv
tb/testbench.sv
